// ===== sv/lfu_cache_lru_tiebreak_macros.svh =====
// Assertion helpers shared by the cache RTL.
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LFU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/lfu_pkg.sv =====
`default_nettype none

package lfu_pkg;

	// Store geometry
	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int USE_W   = 16;
	localparam int STAMP_W = 32;

	localparam logic [USE_W-1:0]  COUNT_MAX  = '1;
	localparam logic [DATA_W-1:0] MISS_VALUE = '1;
	localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);

	// Operation codes
	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	typedef struct packed {
		logic                     func;
		logic signed [KEY_W-1:0]  key;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
	} rsp_t;

	// One entry as seen by the scan unit
	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [DATA_W-1:0]  data;
		logic [USE_W-1:0]   cnt;
		logic [STAMP_W-1:0] stamp;
	} entry_view_t;

	// Scan outcome handed back to the sequencer
	typedef struct packed {
		logic              match;
		logic [IDX_W-1:0]  match_idx;
		logic [DATA_W-1:0] match_data;
		logic [USE_W-1:0]  match_cnt;
		logic              victim_ok;
		logic [IDX_W-1:0]  victim_idx;
		logic              free_ok;
		logic [IDX_W-1:0]  free_idx;
		logic [CNT_W-1:0]  n_valid;
	} scan_res_t;

endpackage

`default_nettype wire

// ===== sv/lfu_cache_lru_tiebreak.sv =====
`default_nettype none

// Fully associative key/value cache with least-frequently-used replacement,
// ties going to the least recently used entry. Raise start with a request
// while busy is low; the request is taken at that edge. With a nonzero
// capacity a single compare unit walks the store entry by entry for the
// key match, the eviction victim and the first free slot before the update;
// done pulses for exactly one cycle with rsp in the cycle after the update,
// and busy is already low then. With capacity zero, done pulses in the
// cycle after the accept. The receiver cannot stall: rsp is valid only
// while done is high. Capacity is written through cfg_we/cfg_wdata; the
// user must write it only while no request is in flight, as the block
// does not enforce this. No clearing pass is needed after reset.
module lfu_cache_lru_tiebreak (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire lfu_pkg::req_t               req,
	output logic                             done,
	output lfu_pkg::rsp_t                    rsp,
	input  wire logic                        cfg_we,
	input  wire logic [lfu_pkg::CAP_W-1:0]   cfg_wdata
);
	import lfu_pkg::*;

`include "lfu_cache_lru_tiebreak_macros.svh"

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t              state_q;
	logic [CAP_W-1:0]    cap_q;
	logic [STAMP_W-1:0]  op_clock_q;
	logic [IDX_W-1:0]    idx_q;
	req_t                req_q;
	logic                done_q;
	rsp_t                rsp_q;

	// Entry store
	logic [ENTRIES-1:0]  valid_q;
	logic [KEY_W-1:0]    key_q   [ENTRIES];
	logic [DATA_W-1:0]   data_q  [ENTRIES];
	logic [USE_W-1:0]    cnt_q   [ENTRIES];
	logic [STAMP_W-1:0]  stamp_q [ENTRIES];

	logic                accept;
	logic [CNT_W-1:0]    eff_cap;
	logic                scan_step;
	entry_view_t         ent;
	scan_res_t           sres;

	// Update decision
	logic                wr_en;
	logic                wr_new;
	logic [IDX_W-1:0]    wr_idx;
	logic [USE_W-1:0]    cnt_inc;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;

	// Capacity saturates at the store size
	always_comb begin
		if (32'(cap_q) > ENTRIES) eff_cap = CNT_W'(ENTRIES);
		else eff_cap = CNT_W'(cap_q);
	end

	// Entry under the scan pointer
	assign scan_step = (state_q == S_SCAN);
	always_comb begin
		ent.valid = valid_q[idx_q];
		ent.key   = key_q[idx_q];
		ent.data  = data_q[idx_q];
		ent.cnt   = cnt_q[idx_q];
		ent.stamp = stamp_q[idx_q];
	end

	lfu_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (accept),
		.step   (scan_step),
		.idx    (idx_q),
		.ent    (ent),
		.key    (req_q.key),
		.res    (sres)
	);

	// Where the update lands
	always_comb begin
		cnt_inc = (sres.match_cnt == COUNT_MAX) ? sres.match_cnt
			: sres.match_cnt + USE_W'(1);
		wr_new  = 1'b0;
		wr_idx  = sres.match_idx;
		wr_en   = 1'b0;
		if (sres.match) begin
			wr_en = 1'b1;
		end else if (req_q.func == FUNC_PUT) begin
			wr_new = 1'b1;
			if ((sres.n_valid >= eff_cap) && sres.victim_ok) begin
				wr_en  = 1'b1;
				wr_idx = sres.victim_idx;
			end else if (sres.free_ok) begin
				wr_en  = 1'b1;
				wr_idx = sres.free_idx;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cap_q      <= CAP_RESET;
			op_clock_q <= '0;
			idx_q      <= '0;
			done_q     <= 1'b0;
			valid_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) cap_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (eff_cap == '0) begin
							done_q <= 1'b1;
						end else begin
							op_clock_q <= op_clock_q + STAMP_W'(1);
							idx_q      <= '0;
							state_q    <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (idx_q == IDX_W'(ENTRIES - 1)) state_q <= S_UPD;
					else idx_q <= idx_q + IDX_W'(1);
				end
				S_UPD: begin
					if (wr_en && wr_new) valid_q[wr_idx] <= 1'b1;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request capture, response and entry payload writes
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q          <= req;
			rsp_q.hit      <= 1'b0;
			rsp_q.read_value <= (req.func == FUNC_PUT) ? '0 : MISS_VALUE;
		end
		if (state_q == S_UPD) begin
			if (sres.match && (req_q.func == FUNC_GET)) begin
				rsp_q.hit        <= 1'b1;
				rsp_q.read_value <= sres.match_data;
			end
			if (wr_en) begin
				stamp_q[wr_idx] <= op_clock_q;
				if (wr_new) begin
					key_q[wr_idx]  <= req_q.key;
					data_q[wr_idx] <= req_q.value;
					cnt_q[wr_idx]  <= USE_W'(1);
				end else begin
					cnt_q[wr_idx] <= cnt_inc;
					if (req_q.func == FUNC_PUT) data_q[wr_idx] <= req_q.value;
				end
			end
		end
	end

	// Checks
	`LFU_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	`LFU_ASSERT_NEXT(a_upd_done, clk, arst_n, state_q == S_UPD, done && !busy)
	`LFU_ASSERT_NEXT(a_start_scan, clk, arst_n, accept && (eff_cap != '0),
		(state_q == S_SCAN) && (idx_q == '0))

endmodule

`default_nettype wire

// ===== sv/lfu_scan.sv =====
`default_nettype none

// Walks the entries one per step: key match, LFU/LRU victim, first free slot.
module lfu_scan (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 clear,
	input  wire logic                 step,
	input  wire logic [lfu_pkg::IDX_W-1:0] idx,
	input  wire lfu_pkg::entry_view_t ent,
	input  wire logic [lfu_pkg::KEY_W-1:0] key,
	output lfu_pkg::scan_res_t        res
);
	import lfu_pkg::*;

	logic                match_q;
	logic [IDX_W-1:0]    match_idx_q;
	logic [DATA_W-1:0]   match_data_q;
	logic [USE_W-1:0]    match_cnt_q;
	logic                victim_ok_q;
	logic [IDX_W-1:0]    victim_idx_q;
	logic                free_ok_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [CNT_W-1:0]    n_valid_q;
	logic [USE_W-1:0]    vic_cnt_q;
	logic [STAMP_W-1:0]  vic_stamp_q;
	logic                is_match;
	logic                is_victim;
	logic                is_free;

	// Shared compare unit for the current entry
	always_comb begin
		is_match  = ent.valid && (ent.key == key) && !match_q;
		is_victim = ent.valid && (!victim_ok_q || (ent.cnt < vic_cnt_q) ||
			((ent.cnt == vic_cnt_q) && (ent.stamp < vic_stamp_q)));
		is_free   = !ent.valid && !free_ok_q;
	end

	// Accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= 1'b0;
			victim_ok_q <= 1'b0;
			free_ok_q   <= 1'b0;
			n_valid_q   <= '0;
		end else if (clear) begin
			match_q     <= 1'b0;
			victim_ok_q <= 1'b0;
			free_ok_q   <= 1'b0;
			n_valid_q   <= '0;
		end else if (step) begin
			if (is_match) match_q <= 1'b1;
			if (is_victim) victim_ok_q <= 1'b1;
			if (is_free) free_ok_q <= 1'b1;
			if (ent.valid) n_valid_q <= n_valid_q + CNT_W'(1);
		end
	end

	// Payload side of the accumulators
	always_ff @(posedge clk) begin
		if (step) begin
			if (is_match) begin
				match_idx_q  <= idx;
				match_data_q <= ent.data;
				match_cnt_q  <= ent.cnt;
			end
			if (is_victim) begin
				victim_idx_q <= idx;
				vic_cnt_q    <= ent.cnt;
				vic_stamp_q  <= ent.stamp;
			end
			if (is_free) free_idx_q <= idx;
		end
	end

	always_comb begin
		res.match      = match_q;
		res.match_idx  = match_idx_q;
		res.match_data = match_data_q;
		res.match_cnt  = match_cnt_q;
		res.victim_ok  = victim_ok_q;
		res.victim_idx = victim_idx_q;
		res.free_ok    = free_ok_q;
		res.free_idx   = free_idx_q;
		res.n_valid    = n_valid_q;
	end

endmodule

`default_nettype wire

// ===== sim/lfu_cache_monitor.sv =====
`default_nettype none

// Watches the request, response and capacity ports of the cache. It keeps its
// own copy of the store, predicts one response per accepted request and
// checks each done pulse against the oldest prediction.
module lfu_cache_monitor
	import lfu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire req_t             req,
	input  wire logic             done,
	input  wire rsp_t             rsp,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata,
	output int                    errors,
	output int                    pending,
	output int                    n_results,
	output int                    n_hits,
	output int                    n_evicts
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the store
	logic [CAP_W-1:0]   capacity_q;
	logic               m_valid [ENTRIES];
	logic [KEY_W-1:0]   m_key   [ENTRIES];
	logic [DATA_W-1:0]  m_data  [ENTRIES];
	logic [USE_W-1:0]   m_uses  [ENTRIES];
	logic [STAMP_W-1:0] m_stamp [ENTRIES];
	logic [STAMP_W-1:0] op_clock;

	rsp_t rsp_expected[$];

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < 40)
			$display("MISMATCH at %0t ns: %s got %h want %h", $time, what, got, want);
		errors++;
	endtask

	// A use: count saturates, stamp takes the current operation clock
	function automatic void note_use(input int s);
		if (m_uses[s] != COUNT_MAX)
			m_uses[s] = m_uses[s] + 1'b1;
		m_stamp[s] = op_clock;
	endfunction

	// Applies one request to the shadow store and returns its response
	function automatic rsp_t cache_predict(input req_t r);
		rsp_t o;
		int   eff, slot, victim, free_slot, n_valid;
		o.hit        = 1'b0;
		o.read_value = (r.func == FUNC_PUT) ? '0 : MISS_VALUE;
		eff = (capacity_q > ENTRIES) ? ENTRIES : int'(capacity_q);
		if (eff == 0)
			return o;
		op_clock = op_clock + 1'b1;

		slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot < 0 && m_valid[i] && m_key[i] == r.key)
				slot = i;

		if (r.func == FUNC_GET) begin
			if (slot >= 0) begin
				o.hit        = 1'b1;
				o.read_value = m_data[slot];
				note_use(slot);
			end
			return o;
		end

		// put to a present key: overwrite and count as a use
		if (slot >= 0) begin
			m_data[slot] = r.value;
			note_use(slot);
			return o;
		end

		// new key: lowest count wins, oldest stamp on ties, lowest index on equal stamps
		victim    = -1;
		free_slot = -1;
		n_valid   = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (m_valid[i]) begin
				n_valid++;
				if (victim < 0 || m_uses[i] < m_uses[victim] ||
						(m_uses[i] == m_uses[victim] && m_stamp[i] < m_stamp[victim]))
					victim = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (n_valid >= eff && victim >= 0) begin
			slot = victim;
			n_evicts++;
		end else begin
			slot = free_slot;
		end
		if (slot < 0)
			return o;
		m_valid[slot] = 1'b1;
		m_key[slot]   = r.key;
		m_data[slot]  = r.value;
		m_uses[slot]  = 1;
		m_stamp[slot] = op_clock;
		return o;
	endfunction

	// Compare finished transfers first, then take config writes and new requests
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			capacity_q = CAP_RESET;
			op_clock   = '0;
			for (int i = 0; i < ENTRIES; i++)
				m_valid[i] = 1'b0;
			rsp_expected.delete();
			errors    = 0;
			n_results = 0;
			n_hits    = 0;
			n_evicts  = 0;
			pending <= 0;
		end else begin
			if (done === 1'b1) begin
				if (rsp_expected.size() == 0) begin
					flag_mismatch("response with none expected", rsp.read_value, '0);
				end else begin
					want = rsp_expected.pop_front();
					if (rsp.hit !== want.hit)
						flag_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
					if (rsp.read_value !== want.read_value)
						flag_mismatch("read_value", rsp.read_value, want.read_value);
					n_results++;
					if (want.hit)
						n_hits++;
				end
			end
			if (cfg_we)
				capacity_q = cfg_wdata;
			if (start && busy === 1'b0)
				rsp_expected.push_back(cache_predict(req));
			pending <= rsp_expected.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_lfu_cache_lru_tiebreak.sv =====
`default_nettype none

module tb_lfu_cache_lru_tiebreak;
	timeunit 1ns;
	timeprecision 1ps;

	import lfu_pkg::*;

	localparam int POOL         = 24;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 66;
	localparam logic [31:0] K_MIN = 32'h8000_0000;
	localparam logic [31:0] K_MAX = 32'h7FFF_FFFF;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	rsp_t             rsp;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	int errors, pending, n_results, n_hits, n_evicts;
	int sent;

	lfu_cache_lru_tiebreak uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	lfu_cache_monitor mon (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending),
		.n_results (n_results),
		.n_hits    (n_hits),
		.n_evicts  (n_evicts)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a run that hangs ends with a mismatch
	initial begin
		#2_000_000;
		$display("lfu_cache_lru_tiebreak: mismatch");
		$finish;
	end

	// Holds start with the request until the transfer is taken
	task automatic issue(input logic f, input logic [31:0] k, input logic [31:0] v);
		start <= 1'b1;
		req   <= '{func: f, key: k, value: v};
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sent++;
	endtask

	task automatic pause_sender(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait until every predicted response has been checked
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [31:0]   key_pool [POOL];
		int unsigned   phase_cap [PHASES];
		int            eff, span;
		logic [31:0]   k;
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		sent      = 0;
		phase_cap = '{4, 1, 0, 9, 31, 2, 16, 5};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: extreme keys and values, hits, overwrite, misses
		issue(FUNC_GET, K_MIN, 32'h1234_5678);
		issue(FUNC_PUT, K_MIN, 32'h7FFF_FFFF);
		issue(FUNC_PUT, K_MAX, 32'h8000_0000);
		issue(FUNC_PUT, 32'h0, 32'h0);
		issue(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(FUNC_GET, K_MIN, 32'h0);
		issue(FUNC_GET, K_MAX, 32'hFFFF_FFFF);
		issue(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
		issue(FUNC_PUT, K_MAX, 32'd12345);
		issue(FUNC_GET, K_MAX, 32'h0);
		issue(FUNC_GET, 32'd5, 32'h0);
		// fill to 16 entries, then a new key evicts the oldest of the count-1 entries
		for (int i = 0; i < 12; i++)
			issue(FUNC_PUT, 32'(100 + i), $urandom);
		issue(FUNC_PUT, 32'd200, 32'hCAFE_F00D);
		issue(FUNC_GET, 32'h0, 32'h0);

		// Random phases over several capacities; small key pool keeps hits and evictions going
		key_pool[0] = K_MIN;
		key_pool[1] = K_MAX;
		key_pool[2] = 32'h0;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL; i++)
			key_pool[i] = $urandom;
		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(CAP_W'(phase_cap[ph]));
			eff  = (phase_cap[ph] > ENTRIES) ? ENTRIES : int'(phase_cap[ph]);
			span = (eff + 6 > POOL) ? POOL : eff + 6;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 99) < 80)
					k = key_pool[$urandom_range(0, span - 1)];
				else
					k = $urandom;
				issue(logic'($urandom_range(0, 1)), k, $urandom);
				// phases 3 and 4 run back to back with no gaps
				if ((ph < 3 || ph > 4) && $urandom_range(0, 99) < 14)
					pause_sender($urandom_range(1, 20));
				if (ph == 5 && i == PHASE_ITEMS / 2)
					drain();
			end
		end

		drain();
		repeat (40) @(posedge clk);
		$display("Ran %0d requests: %0d responses checked, %0d hits, %0d evictions,",
			sent, n_results, n_hits, n_evicts);
		$display("capacities from 0 to 31, shrinking below the fill level, extreme keys.");
		if (errors == 0 && pending == 0)
			$display("lfu_cache_lru_tiebreak: match");
		else
			$display("lfu_cache_lru_tiebreak: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/lfu_pkg.sv
sv/lfu_scan.sv
sv/lfu_cache_lru_tiebreak.sv
sim/lfu_cache_monitor.sv
sim/tb_lfu_cache_lru_tiebreak.sv
